@@ rtl/swlrl_pkg.sv @@
// swlrl_pkg: field widths and register indexes of the sliding window log rate limiter.
// No dependencies.
`timescale 1ns / 1ps

package swlrl_pkg;

	// Port field widths
	localparam int ARRIVAL_W = 32;
	localparam int LIMIT_W   = 5;
	localparam int WINDOW_W  = 31;
	localparam int COUNT_W   = 5;

	// Configuration port
	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W  = 31;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_REQUEST_LIMIT = 1'b0,
		REG_WINDOW_TICKS  = 1'b1
	} cfg_reg_t;

	// Reset values of the registers
	localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = 5'd3;
	localparam logic [WINDOW_W-1:0] WINDOW_RESET = 31'd1000;

endpackage

@@ rtl/swlrl_stamp_ram.sv @@
// swlrl_stamp_ram: simple dual port timestamp store, one write and one registered read.
// No dependencies.
`timescale 1ns / 1ps

module swlrl_stamp_ram #(
	parameter int DEPTH  = 16,
	parameter int DATA_W = 32,
	parameter int ADDR_W = 4
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [DATA_W-1:0] wr_data,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [DATA_W-1:0] rd_data
);

	logic [DATA_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// read-first, registered read
	always_ff @(posedge clk) begin
		rd_data <= mem_q[rd_addr];
	end

endmodule

@@ rtl/sliding_window_log_rate_limiter.sv @@
// sliding_window_log_rate_limiter: top level, request scan and decide sequencer.
// Depends on swlrl_pkg and swlrl_stamp_ram.
`timescale 1ns / 1ps

// Sliding window log rate limiter. Each input transfer is one request carrying
// its arrival timestamp (non-decreasing, wrapping modulo 2^TIME_BITS). The block
// holds the stamps of allowed requests in a ring memory of MAX_ENTRIES entries.
// For each request it walks the ring from the oldest stamp, dropping every stamp
// whose age (now - stamp, with wrap) is at least window_ticks, then allows the
// request if fewer than request_limit stamps remain (the limit is clamped to
// MAX_ENTRIES) and records its stamp. One output transfer per request gives the
// allow flag and the count of stamps held afterwards.
// Timing: one request at a time; input is accepted only in the idle state. After
// an input transfer the sequencer scans the ring, examining every dropped stamp
// plus the first young stamp if one is left (none with an empty ring, up to
// MAX_ENTRIES), then decides and pushes, then returns to accept. The ring memory
// port yields one stamp per cycle to the age compare. The decide step waits while
// a previous result still sits unclaimed in the output register; input is taken
// regardless. Configuration (cfg_we, cfg_index, cfg_data) must be written only
// while idle; the block itself does not enforce this.
// The ring needs no clearing after reset: only held entries are ever read.

module sliding_window_log_rate_limiter #(
	parameter int MAX_ENTRIES = 16,
	parameter int TIME_BITS   = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration
	input  logic                                cfg_we,
	input  logic [swlrl_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [swlrl_pkg::CFG_DATA_W-1:0]    cfg_data,
	// request channel
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [swlrl_pkg::ARRIVAL_W-1:0]     arrival_time,
	// result channel
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                allowed,
	output logic [swlrl_pkg::COUNT_W-1:0]       window_count
);

	import swlrl_pkg::*;

	localparam int IDX_W   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CNT_W   = $clog2(MAX_ENTRIES + 1);
	localparam int SUM_W   = CNT_W + 1;
	localparam int ARR_X_W = (TIME_BITS > ARRIVAL_W) ? TIME_BITS : ARRIVAL_W;
	localparam int AGE_W   = (TIME_BITS > WINDOW_W) ? TIME_BITS : WINDOW_W;
	localparam int LIM_X_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
	localparam int OUT_X_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

	localparam logic [IDX_W-1:0]   LAST_IDX  = IDX_W'(MAX_ENTRIES - 1);
	localparam logic [SUM_W-1:0]   DEPTH_SUM = SUM_W'(MAX_ENTRIES);
	localparam logic [LIM_X_W-1:0] DEPTH_LIM = LIM_X_W'(MAX_ENTRIES);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DECIDE
	} state_t;

	state_t               state_q;
	logic [LIMIT_W-1:0]   limit_q;
	logic [WINDOW_W-1:0]  window_q;
	logic [IDX_W-1:0]     oldest_q;
	logic [CNT_W-1:0]     count_q;
	logic [TIME_BITS-1:0] now_q;
	logic [CNT_W-1:0]     eff_limit_q;
	logic                 out_valid_q;
	logic                 allowed_q;
	logic [CNT_W-1:0]     result_count_q;

	// request timestamp reduced to TIME_BITS
	logic [ARR_X_W-1:0]   arrival_x;
	logic [TIME_BITS-1:0] now_in;
	assign arrival_x = ARR_X_W'(arrival_time);
	assign now_in    = arrival_x[TIME_BITS-1:0];

	// limit clamped to ring depth
	logic [LIM_X_W-1:0] limit_x;
	logic [CNT_W-1:0]   eff_limit;
	always_comb begin
		limit_x = LIM_X_W'(limit_q);
		if (limit_x > DEPTH_LIM) begin
			limit_x = DEPTH_LIM;
		end
		eff_limit = limit_x[CNT_W-1:0];
	end

	// ring memory
	logic [IDX_W-1:0]     rd_addr;
	logic [TIME_BITS-1:0] rd_stamp;
	logic                 wr_en;
	logic [IDX_W-1:0]     wr_addr;

	swlrl_stamp_ram #(
		.DEPTH  (MAX_ENTRIES),
		.DATA_W (TIME_BITS),
		.ADDR_W (IDX_W)
	) u_ring (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (now_q),
		.rd_addr (rd_addr),
		.rd_data (rd_stamp)
	);

	// age of the stamp at the oldest end, read last cycle
	logic [TIME_BITS-1:0] age;
	logic                 expired;
	assign age     = now_q - rd_stamp;
	assign expired = AGE_W'(age) >= AGE_W'(window_q);

	logic [IDX_W-1:0] oldest_inc;
	assign oldest_inc = (oldest_q == LAST_IDX) ? '0 : oldest_q + 1'b1;

	// next read goes to the new oldest entry after a drop
	assign rd_addr = (state_q == ST_SCAN && expired) ? oldest_inc : oldest_q;

	// push position: oldest + count, wrapped once
	logic [SUM_W-1:0] push_sum;
	always_comb begin
		push_sum = SUM_W'(oldest_q) + SUM_W'(count_q);
		if (push_sum >= DEPTH_SUM) begin
			push_sum = push_sum - DEPTH_SUM;
		end
		wr_addr = push_sum[IDX_W-1:0];
	end

	logic out_free;
	logic do_push;
	assign out_free = !out_valid_q || !out_stall;
	assign do_push  = count_q < eff_limit_q;
	assign wr_en    = (state_q == ST_DECIDE) && out_free && do_push;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			oldest_q       <= '0;
			count_q        <= '0;
			out_valid_q    <= 1'b0;
			allowed_q      <= 1'b0;
			result_count_q <= '0;
		end else begin
			// result register: loaded by the decide step, emptied by a transfer
			out_valid_q <= (out_valid_q && out_stall) || (state_q == ST_DECIDE && out_free);
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= (count_q == '0) ? ST_DECIDE : ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (expired) begin
						oldest_q <= oldest_inc;
						count_q  <= count_q - 1'b1;
						if (count_q == CNT_W'(1)) begin
							state_q <= ST_DECIDE;
						end
					end else begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					if (out_free) begin
						if (do_push) begin
							count_q <= count_q + 1'b1;
						end
						allowed_q      <= do_push;
						result_count_q <= do_push ? count_q + 1'b1 : count_q;
						state_q        <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// request payload, latched at the input transfer
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			now_q       <= now_in;
			eff_limit_q <= eff_limit;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q  <= LIMIT_RESET;
			window_q <= WINDOW_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_REQUEST_LIMIT: limit_q  <= cfg_data[LIMIT_W-1:0];
				REG_WINDOW_TICKS:  window_q <= cfg_data[WINDOW_W-1:0];
				default: ;
			endcase
		end
	end

	logic [OUT_X_W-1:0] count_x;
	assign count_x = OUT_X_W'(result_count_q);

	assign in_stall     = (state_q != ST_IDLE);
	assign out_valid    = out_valid_q;
	assign allowed      = allowed_q;
	assign window_count = count_x[COUNT_W-1:0];

endmodule

@@ bench/tb_sliding_window_log_rate_limiter.sv @@
// tb_sliding_window_log_rate_limiter: self-checking bench for the sliding window log rate limiter.
// Depends on swlrl_pkg and the sliding_window_log_rate_limiter RTL; nothing else.
`timescale 1ns / 1ps

module tb_sliding_window_log_rate_limiter;
	import swlrl_pkg::*;

	localparam int MAX_ENTRIES = 16;
	localparam int TIME_BITS   = 32;
	// cycles without any transfer before the run is declared hung
	localparam int HANG_LIMIT  = 5000;
	// hold-off length used to back the block up
	localparam int HOLDOFF_CYCLES = 80;
	// slots of the expected-verdict ring, far above what can be in flight
	localparam int VERDICT_SLOTS = 64;

	// one expected verdict per request
	typedef struct packed {
		logic               allowed;
		logic [COUNT_W-1:0] window_count;
	} verdict_t;

	// DUT ports; every input is known from time zero
	logic                 clk          = 1'b0;
	logic                 arst_n       = 1'b0;
	logic                 cfg_we       = 1'b0;
	cfg_reg_t             cfg_index    = REG_REQUEST_LIMIT;
	logic [CFG_DATA_W-1:0] cfg_data    = '0;
	logic                 in_valid     = 1'b0;
	logic                 in_stall;
	logic [ARRIVAL_W-1:0] arrival_time = '0;
	logic                 out_valid;
	logic                 out_stall    = 1'b0;
	logic                 allowed;
	logic [COUNT_W-1:0]   window_count;

	// bench's own copy of the limiter: registers, stamp log, head and fill
	logic [LIMIT_W-1:0]   limit_reg  = LIMIT_RESET;
	logic [WINDOW_W-1:0]  window_reg = WINDOW_RESET;
	logic [ARRIVAL_W-1:0] stamp_log [MAX_ENTRIES];
	logic [3:0]           oldest_pos = '0;
	logic [COUNT_W-1:0]   held_count = '0;

	// expected verdicts in request order; the sender advances verdict_wr,
	// the checker advances verdict_rd
	verdict_t verdict_ring [VERDICT_SLOTS];
	int       verdict_wr = 0;
	int       verdict_rd = 0;

	// traffic shaping knobs, percent of cycles
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	// hold-off request: a new id asks the receiver for holdoff_len stall cycles
	int holdoff_len    = 0;
	int holdoff_id     = 0;

	// bookkeeping
	int requests_sent  = 0;
	int verdicts_seen  = 0;
	int allowed_seen   = 0;
	int mismatch_count = 0;
	int unexpected_count = 0;
	int settings_used  = 0;
	logic [ARRIVAL_W-1:0] now_tick = '0;

	sliding_window_log_rate_limiter #(
		.MAX_ENTRIES (MAX_ENTRIES),
		.TIME_BITS   (TIME_BITS)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.arrival_time (arrival_time),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.allowed      (allowed),
		.window_count (window_count)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// Predictor: expire from the oldest end while age >= window (age taken
	// with 32-bit wrap), then admit if the fill is under the clamped limit.
	function automatic verdict_t judge_request(input logic [ARRIVAL_W-1:0] stamp);
		logic [COUNT_W-1:0] cap;
		logic [3:0]         slot;
		verdict_t           v;
		cap = (limit_reg > MAX_ENTRIES) ? COUNT_W'(MAX_ENTRIES) : limit_reg;
		while (held_count != 0 &&
			ARRIVAL_W'(stamp - stamp_log[oldest_pos]) >= {1'b0, window_reg}) begin
			oldest_pos = oldest_pos + 4'd1;
			held_count = held_count - 1'b1;
		end
		v.allowed = 1'b0;
		if (held_count < cap) begin
			slot = oldest_pos + held_count[3:0];
			stamp_log[slot] = stamp;
			held_count = held_count + 1'b1;
			v.allowed = 1'b1;
		end
		v.window_count = held_count;
		return v;
	endfunction

	// One request transfer. Idle cycles drop valid first; once accepted, valid
	// is left high so a back-to-back request never toggles it within a step.
	task automatic offer_request(input logic [ARRIVAL_W-1:0] stamp);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid     <= 1'b1;
		arrival_time <= stamp;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		verdict_ring[verdict_wr % VERDICT_SLOTS] = judge_request(stamp);
		verdict_wr++;
		requests_sent++;
	endtask

	// Sender stops and waits for every verdict, then waits on the clock so the
	// sequencer is back in accept before registers are touched.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (verdict_wr != verdict_rd) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Both registers in consecutive cycles; write enable drops afterwards.
	task automatic set_limits(input logic [LIMIT_W-1:0] lim, input logic [WINDOW_W-1:0] win);
		cfg_we    <= 1'b1;
		cfg_index <= REG_REQUEST_LIMIT;
		cfg_data  <= CFG_DATA_W'(lim);
		@(posedge clk);
		limit_reg = lim;
		cfg_index <= REG_WINDOW_TICKS;
		cfg_data  <= win;
		@(posedge clk);
		window_reg = win;
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	// Mostly monotonic time paced around window/limit so the log keeps filling
	// and draining; a few same-tick bursts, wild jumps and small rewinds.
	function automatic logic [ARRIVAL_W-1:0] next_arrival(input logic [ARRIVAL_W-1:0] t);
		logic [63:0] span;
		int          pick;
		span = ({33'd0, window_reg} * 2) / ((limit_reg == 0) ? 64'd1 : 64'(limit_reg));
		if (span == 0)
			span = 1;
		if (span > 64'hFFFF_FFFF)
			span = 64'hFFFF_FFFF;
		pick = $urandom_range(99);
		if (pick < 84)
			return t + $urandom_range(span[31:0]);
		else if (pick < 92)
			return t;
		else if (pick < 96)
			return t + $urandom();
		else
			return t - $urandom_range(64, 1);
	endfunction

	// --- directed tests ---

	// reset values: limit 3, window 1000
	task automatic test_reset_defaults();
		offer_request(32'd0);
		offer_request(32'd0);
		offer_request(32'd0);
		offer_request(32'd999);   // still inside the window: denied
		offer_request(32'd1000);  // all three age out exactly at the window
		wait_idle();
	endtask

	// zero limit denies and stores nothing
	task automatic test_zero_limit();
		set_limits(5'd0, 31'd1);
		offer_request(32'd2000);
		wait_idle();
	endtask

	// limit above ring depth acts as depth; ring fills and wraps its index
	task automatic test_clamped_full_ring();
		set_limits(5'd31, 31'h7FFF_FFFF);
		repeat (17) offer_request(32'hFFFF_FFFF);
		wait_idle();
	endtask

	// a stamp in the past makes every held entry look ancient: full expiry
	task automatic test_time_reversal();
		set_limits(5'd31, 31'd1000);
		offer_request(32'hFFFF_FFF0);
		offer_request(32'h0000_0005);  // forward across the wrap, still young
		wait_idle();
	endtask

	// zero window expires everything before each decision
	task automatic test_zero_window();
		set_limits(5'd2, 31'd0);
		offer_request(32'd5);
		offer_request(32'd5);
		wait_idle();
		now_tick = 32'd5;
	endtask

	// --- random traffic, six settings per pass ---
	task automatic test_random_traffic(input int sidle, input int rstall);
		logic [LIMIT_W-1:0]  lim;
		logic [WINDOW_W-1:0] win;
		int                  pick;
		send_idle_pct  = sidle;
		recv_stall_pct = rstall;
		for (int seg = 0; seg < 6; seg++) begin
			wait_idle();
			case (seg)
				0: begin
					lim = 5'd16;
					win = 31'h7FFF_FFFF;
				end
				1: begin
					lim = 5'd1;
					win = 31'd1;
				end
				default: begin
					pick = $urandom_range(9);
					lim = (pick == 0) ? 5'd0 :
						(pick == 1) ? LIMIT_W'($urandom_range(31, 17)) :
						LIMIT_W'($urandom_range(16, 1));
					pick = $urandom_range(9);
					win = (pick < 4) ? WINDOW_W'($urandom_range(64, 1)) :
						(pick < 8) ? WINDOW_W'($urandom_range(5000, 1)) :
						WINDOW_W'($urandom());
				end
			endcase
			set_limits(lim, win);
			// occasional jump so the high time bits move too
			if ($urandom_range(1))
				now_tick = $urandom();
			repeat (105) begin
				now_tick = next_arrival(now_tick);
				offer_request(now_tick);
			end
		end
		wait_idle();
	endtask

	// receiver holds off while the sender keeps offering, so the result
	// register fills and the input stalls; then the sender pauses until
	// all verdicts are in before it starts again
	task automatic test_backpressure();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		set_limits(5'd4, 31'd40);
		holdoff_len = HOLDOFF_CYCLES;
		holdoff_id++;
		repeat (12) begin
			now_tick = now_tick + $urandom_range(15);
			offer_request(now_tick);
		end
		wait_idle();
		repeat (6) begin
			now_tick = now_tick + $urandom_range(15);
			offer_request(now_tick);
		end
		wait_idle();
	endtask

	// Receiver stall: random per cycle, or a counted hold-off when requested.
	always @(posedge clk) begin
		static int holdoff_left = 0;
		static int holdoff_done = 0;
		if (holdoff_id != holdoff_done) begin
			holdoff_left = holdoff_len;
			holdoff_done = holdoff_id;
		end
		if (holdoff_left > 0) begin
			holdoff_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// Verdict checker: every output transfer against the oldest prediction.
	always @(posedge clk) begin
		verdict_t want;
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (verdict_wr == verdict_rd) begin
				unexpected_count++;
				if (mismatch_count + unexpected_count <= 10)
					$display("unexpected result: allowed=%0d count=%0d", allowed, window_count);
			end else begin
				want = verdict_ring[verdict_rd % VERDICT_SLOTS];
				verdict_rd++;
				verdicts_seen++;
				if (want.allowed)
					allowed_seen++;
				if (allowed !== want.allowed || window_count !== want.window_count) begin
					mismatch_count++;
					if (mismatch_count + unexpected_count <= 10)
						$display("mismatch: expected allowed=%0d count=%0d, got allowed=%0d count=%0d",
							want.allowed, want.window_count, allowed, window_count);
				end
			end
		end
	end

	// Hang detector: cycles with no transfer on either channel.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < HANG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid === 1'b1 && !out_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("timeout: no transfer for %0d cycles", HANG_LIMIT);
		$display("Verification failed");
		$finish;
	end

	initial begin
		int failures;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part runs under the first idling mix
		send_idle_pct  = 13;
		recv_stall_pct = 72;
		test_reset_defaults();
		test_zero_limit();
		test_clamped_full_ring();
		test_time_reversal();
		test_zero_window();

		test_random_traffic(13, 72);
		test_backpressure();
		test_random_traffic(72, 13);
		test_random_traffic(0, 0);

		in_valid <= 1'b0;
		while (verdict_wr != verdict_rd) @(posedge clk);
		repeat (20) @(posedge clk);

		failures = mismatch_count + unexpected_count + (verdict_wr - verdict_rd);
		$display("covered %0d requests over %0d limit/window settings, %0d verdicts checked",
			requests_sent, settings_used, verdicts_seen);
		$display("%0d admitted, %0d refused, %0d mismatches, %0d unexpected",
			allowed_seen, verdicts_seen - allowed_seen, mismatch_count, unexpected_count);
		if (failures == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
